[design/efa_pkg.sv]
// ============================================================================
// efa_pkg
// Shared widths, constants and latencies of the error function unit.
// ============================================================================
`default_nettype none

package efa_pkg;

  // Argument and result widths.
  localparam int X_W = 16;
  localparam int A_W = 17;   // |x|, 0..32768, Q.12
  localparam int R_W = 16;

  // Reciprocal t = 1 / (1 + P*a).
  localparam int D_W  = 38;  // divisor, Q.36
  localparam int NM_W = 61;  // dividend 2^60 + d/2
  localparam int T_W  = 25;  // quotient, Q.24, at most 2^24
  localparam int DIV_STEPS = T_W;
  localparam int RECIP_LAT = DIV_STEPS + 1;
  localparam logic [22:0] COEF_P = 23'd5496067;

  // Horner polynomial in t.
  localparam int ACC_W = 28;
  localparam int POLY_STEPS = 5;
  localparam int POLY_LAT = POLY_STEPS;
  localparam logic signed [ACC_W-1:0] COEF_A4 = 28'sd17807428;
  localparam logic signed [ACC_W-1:0] POLY_ADD [POLY_STEPS] = '{
    -28'sd24379845, 28'sd23847365, -28'sd4773063, 28'sd4275331, 28'sd0
  };

  // exp(-a*a) in Q.30.
  localparam int C_W = 31;
  localparam int U_W = 27;
  localparam int N_W = 6;
  localparam logic [N_W-1:0] EXP_INT_CAP = 6'd32;
  localparam int TAYLOR_STEPS = 6;
  localparam int SQ_STEPS = 3;
  localparam int E1_STEPS = 32;
  localparam int EXP_LAT = 1 + 3 * TAYLOR_STEPS + SQ_STEPS + E1_STEPS;
  localparam logic [C_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [29:0] EXP_M1 = 30'd395007542;
  localparam logic [2:0]  DIVK   [TAYLOR_STEPS] = '{3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1};
  // floor(2^32 / k) for the divisors above.
  localparam logic [32:0] DIVK_M [TAYLOR_STEPS] = '{
    33'd715827882, 33'd858993459, 33'd1073741824,
    33'd1431655765, 33'd2147483648, 33'd4294967296
  };

  // The polynomial result waits in a delay line until exp(-a*a) is ready.
  localparam int ALIGN = EXP_LAT - RECIP_LAT - POLY_LAT;

  localparam logic signed [20:0] ERF_ONE = 21'sd32768;
  localparam logic signed [20:0] ERF_MAX = 21'sd32767;

endpackage

`default_nettype wire

[design/efa_recip.sv]
// ============================================================================
// efa_recip
// Pipelined restoring divider for t = (2^60 + d/2) / d, one bit per stage.
// ============================================================================
`default_nettype none

module efa_recip
  import efa_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire logic [A_W-1:0] in_a,
  output logic                out_vld,
  output logic [T_W-1:0]      out_t
);

  logic [NM_W-1:0] rem_r [DIV_STEPS+1];
  logic [D_W-1:0]  d_r   [DIV_STEPS+1];
  logic [T_W-1:0]  q_r   [DIV_STEPS+1];
  logic            vld_r [DIV_STEPS+1];

  // Stage 0 forms the divisor d = 2^36 + P*a and the rounded dividend.
  logic [D_W-1:0] d_nxt;
  always_comb begin
    d_nxt = (D_W'(1) << 36) + (D_W'(COEF_P) * D_W'(in_a));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    d_r[0]   <= d_nxt;
    rem_r[0] <= (NM_W'(1) << 60) + NM_W'(d_nxt >> 1);
    q_r[0]   <= '0;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    logic [NM_W+1:0] dsh;
    logic [NM_W+1:0] remx;
    logic            take;
    always_comb begin
      dsh  = (NM_W+2)'(d_r[j]) << SH;
      remx = (NM_W+2)'(rem_r[j]);
      take = (remx >= dsh);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
      d_r[j+1]   <= d_r[j];
      rem_r[j+1] <= take ? rem_r[j] - dsh[NM_W-1:0] : rem_r[j];
      q_r[j+1]   <= {q_r[j][T_W-2:0], take};
    end
  end

  assign out_vld = vld_r[DIV_STEPS];
  assign out_t   = q_r[DIV_STEPS];

endmodule

`default_nettype wire

[design/efa_poly.sv]
// ============================================================================
// efa_poly
// Horner evaluation of the fifth-degree polynomial in t, one term per stage.
// ============================================================================
`default_nettype none

module efa_poly
  import efa_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_vld,
  input  wire logic [T_W-1:0]          in_t,
  output logic                         out_vld,
  output logic signed [ACC_W-1:0]      out_sum
);

  logic                    vld_r [POLY_STEPS];
  logic [T_W-1:0]          t_r   [POLY_STEPS];
  logic signed [ACC_W-1:0] acc_r [POLY_STEPS];

  for (genvar j = 0; j < POLY_STEPS; j++) begin : g_hrn
    logic                    v_in;
    logic [T_W-1:0]          t_in;
    logic signed [ACC_W-1:0] a_in;
    if (j == 0) begin : g_first
      assign v_in = in_vld;
      assign t_in = in_t;
      assign a_in = COEF_A4;
    end else begin : g_next
      assign v_in = vld_r[j-1];
      assign t_in = t_r[j-1];
      assign a_in = acc_r[j-1];
    end

    // Product rounded half away from zero on the magnitude.
    logic [ACC_W-1:0]        mag;
    logic [ACC_W+T_W:0]      prod;
    logic [ACC_W-1:0]        pm;
    logic signed [ACC_W-1:0] term;
    always_comb begin
      mag  = a_in[ACC_W-1] ? ACC_W'(-a_in) : ACC_W'(a_in);
      prod = (ACC_W+T_W+1)'(mag) * (ACC_W+T_W+1)'(t_in) + (ACC_W+T_W+1)'(1 << 23);
      pm   = prod[ACC_W+23:24];
      term = a_in[ACC_W-1] ? -$signed(pm) : $signed(pm);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= v_in;
      end
      t_r[j]   <= t_in;
      acc_r[j] <= POLY_ADD[j] + term;
    end
  end

  assign out_vld = vld_r[POLY_STEPS-1];
  assign out_sum = acc_r[POLY_STEPS-1];

endmodule

`default_nettype wire

[design/efa_exp.sv]
// ============================================================================
// efa_exp
// Pipelined exp(-a*a) in Q.30: Taylor series on the fraction, three
// squarings, then one multiply by e^-1 per stage for the integer part.
// ============================================================================
`default_nettype none

module efa_exp
  import efa_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire logic [A_W-1:0] in_a,
  output logic                out_vld,
  output logic [C_W-1:0]      out_e
);

  logic           vld_r [EXP_LAT];
  logic [C_W-1:0] c_r   [EXP_LAT];
  logic [U_W-1:0] u_r   [EXP_LAT];
  logic [N_W-1:0] n_r   [EXP_LAT];
  logic [U_W-1:0] pv_r  [EXP_LAT];
  logic [U_W-1:0] qe_r  [EXP_LAT];

  // Stage 0 splits a*a into its integer part and a fraction scaled by 1/8.
  logic [C_W-1:0] sq_in;
  logic [6:0]     n_full;
  always_comb begin
    sq_in  = C_W'(in_a) * C_W'(in_a);
    n_full = sq_in[30:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    c_r[0]  <= Q30_ONE;
    u_r[0]  <= {sq_in[23:0], 3'b000};
    n_r[0]  <= (n_full > 7'(EXP_INT_CAP)) ? EXP_INT_CAP : n_full[N_W-1:0];
    pv_r[0] <= '0;
    qe_r[0] <= '0;
  end

  for (genvar s = 1; s < EXP_LAT; s++) begin : g_stg
    logic [C_W-1:0] c_nxt;
    logic [U_W-1:0] pv_nxt;
    logic [U_W-1:0] qe_nxt;

    if (s <= 3 * TAYLOR_STEPS) begin : g_tay
      localparam int KI = (s - 1) / 3;
      localparam int PH = (s - 1) % 3;
      logic [57:0] prod;
      logic [59:0] prod_m;
      logic [29:0] qk;
      logic [29:0] rem;
      logic [U_W-1:0] q;
      always_comb begin
        prod   = 58'(u_r[s-1]) * 58'(c_r[s-1]);
        prod_m = 60'(pv_r[s-1]) * 60'(DIVK_M[KI]);
        qk     = 30'(qe_r[s-1]) * 30'(DIVK[KI]);
        rem    = 30'(pv_r[s-1]) - qk;
        q      = (rem >= 30'(DIVK[KI])) ? qe_r[s-1] + U_W'(1) : qe_r[s-1];
        c_nxt  = c_r[s-1];
        pv_nxt = pv_r[s-1];
        qe_nxt = qe_r[s-1];
        if (PH == 0) begin
          pv_nxt = prod[56:30];
        end else if (PH == 1) begin
          qe_nxt = prod_m[58:32];
        end else begin
          c_nxt = Q30_ONE - C_W'(q);
        end
      end
    end else if (s <= 3 * TAYLOR_STEPS + SQ_STEPS) begin : g_sq
      logic [61:0] sq;
      always_comb begin
        sq     = 62'(c_r[s-1]) * 62'(c_r[s-1]) + 62'(1 << 29);
        c_nxt  = sq[60:30];
        pv_nxt = pv_r[s-1];
        qe_nxt = qe_r[s-1];
      end
    end else begin : g_e1
      localparam int J = s - 1 - 3 * TAYLOR_STEPS - SQ_STEPS;
      logic [60:0] pe;
      always_comb begin
        pe     = 61'(c_r[s-1]) * 61'(EXP_M1) + 61'(1 << 29);
        c_nxt  = (n_r[s-1] > N_W'(J)) ? pe[60:30] : c_r[s-1];
        pv_nxt = pv_r[s-1];
        qe_nxt = qe_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
      c_r[s]  <= c_nxt;
      u_r[s]  <= u_r[s-1];
      n_r[s]  <= n_r[s-1];
      pv_r[s] <= pv_nxt;
      qe_r[s] <= qe_nxt;
    end
  end

  assign out_vld = vld_r[EXP_LAT-1];
  assign out_e   = c_r[EXP_LAT-1];

endmodule

`default_nettype wire

[design/error_function_approximation_unit.sv]
// ============================================================================
// error_function_approximation_unit
// Fully pipelined erf(x) by the Abramowitz-Stegun 7.1.26 approximation.
// ============================================================================
//
//  Channel  Ports                        Transaction
//  -------  ---------------------------  ------------------------------------
//  input    start, busy, in_x_value      accepted when start is high, busy low
//  result   out_strobe, out_erf_value    valid for the one cycle out_strobe is
//                                        high; the receiver takes it then
//
// One argument is accepted every clock cycle; busy is always low because the
// datapath never stalls. Each result passes from its input transaction through
// the input register, the exp(-a*a) pipeline that sets the depth (one Taylor
// step every three stages, three squarings and one e^-1 multiply per stage for
// up to 32 integer steps), and the final multiply and clamp registers.
// Reset (rst_n low, synchronous) clears only the valid bits, so everything in
// flight is dropped and no strobe appears until new arguments arrive.
//
// Datapath: the input stage takes |x|. Two branches then run side by side: a
// 25-stage restoring divider and a 5-stage Horner pipeline produce the
// polynomial S(t), while the exp branch produces exp(-a*a). S waits in a delay
// line so both meet at the final multiply, which forms 1 - S*exp(-a*a). The
// last stage clamps to +-32767 and restores the sign of the argument.
// ============================================================================
`default_nettype none

module error_function_approximation_unit
  import efa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [X_W-1:0] in_x_value,
  output logic                       out_strobe,
  output logic signed [R_W-1:0]      out_erf_value
);

  // The pipeline accepts a transaction every cycle.
  assign busy = 1'b0;

  // Input stage: magnitude and sign of the argument.
  logic           vin_r;
  logic [A_W-1:0] a_r;
  logic           neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_r <= 1'b0;
    end else begin
      vin_r <= start && !busy;
    end
    neg_r <= in_x_value[X_W-1];
    a_r   <= in_x_value[X_W-1] ? A_W'(-$signed({in_x_value[X_W-1], in_x_value}))
                               : A_W'(in_x_value);
  end

  // Reciprocal and polynomial branch.
  logic                    t_vld;
  logic [T_W-1:0]          t_val;
  logic                    s_vld;
  logic signed [ACC_W-1:0] s_val;

  efa_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vin_r),
    .in_a    (a_r),
    .out_vld (t_vld),
    .out_t   (t_val)
  );

  efa_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (t_vld),
    .in_t    (t_val),
    .out_vld (s_vld),
    .out_sum (s_val)
  );

  // Exponential branch.
  logic           e_vld;
  logic [C_W-1:0] e_val;

  efa_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vin_r),
    .in_a    (a_r),
    .out_vld (e_vld),
    .out_e   (e_val)
  );

  // Delay lines that line S and the sign up with exp(-a*a).
  logic signed [ACC_W-1:0] sd_r  [ALIGN];
  logic                    sdv_r [ALIGN];
  logic                    nd_r  [EXP_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdv_r[0] <= 1'b0;
    end else begin
      sdv_r[0] <= s_vld;
    end
    sd_r[0] <= s_val;
    nd_r[0] <= neg_r;
  end

  for (genvar i = 1; i < ALIGN; i++) begin : g_sdly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sdv_r[i] <= 1'b0;
      end else begin
        sdv_r[i] <= sdv_r[i-1];
      end
      sd_r[i] <= sd_r[i-1];
    end
  end

  for (genvar i = 1; i < EXP_LAT; i++) begin : g_ndly
    always_ff @(posedge clk) begin
      nd_r[i] <= nd_r[i-1];
    end
  end

  // Final multiply: r = 1.0 - S*E, rounded half away from zero at bit 39.
  logic signed [ACC_W-1:0] s_al;
  logic [ACC_W-1:0]        s_mag;
  logic [ACC_W+C_W:0]      se_prod;
  logic [19:0]             se_mag;
  logic signed [20:0]      se_term;
  logic signed [20:0]      r_nxt;
  logic                    f1_vld_r;
  logic signed [20:0]      r_r;
  logic                    f1_neg_r;

  always_comb begin
    s_al    = sd_r[ALIGN-1];
    s_mag   = s_al[ACC_W-1] ? ACC_W'(-s_al) : ACC_W'(s_al);
    se_prod = (ACC_W+C_W+1)'(s_mag) * (ACC_W+C_W+1)'(e_val)
              + ((ACC_W+C_W+1)'(1) << 38);
    se_mag  = se_prod[58:39];
    se_term = s_al[ACC_W-1] ? -$signed({1'b0, se_mag}) : $signed({1'b0, se_mag});
    r_nxt   = ERF_ONE - se_term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= e_vld && sdv_r[ALIGN-1];
    end
    r_r      <= r_nxt;
    f1_neg_r <= nd_r[EXP_LAT-1];
  end

  // Clamp to the Q1.15 range and mirror the sign for negative arguments.
  logic signed [20:0] r_clamp;
  logic signed [20:0] r_signed;

  always_comb begin
    priority if (r_r > ERF_MAX) begin
      r_clamp = ERF_MAX;
    end else if (r_r < -ERF_MAX) begin
      r_clamp = -ERF_MAX;
    end else begin
      r_clamp = r_r;
    end
    r_signed = f1_neg_r ? -r_clamp : r_clamp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= f1_vld_r;
    end
    out_erf_value <= R_W'(r_signed);
  end

endmodule

`default_nettype wire
